// ===== rtl/dlsr_pkg.sv =====
package dlsr_pkg;

    localparam int COLUMNS_DEF    = 40;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int PIX_W   = 16;
    localparam int DOT_W   = 7;
    localparam int ACC_W   = 3 * DOT_W;
    localparam int HELD_W  = $clog2(ACC_W + 1);
    localparam int REG_W   = 64;
    localparam int NUM_REGS = 7;
    localparam int ADDR_W  = $clog2(8 * NUM_REGS);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_MONO     = 3'd0,
        REG_FORE     = 3'd1,
        REG_BACK     = 3'd2,
        REG_PAL_LOW  = 3'd3,
        REG_PAL_MLOW = 3'd4,
        REG_PAL_MHIGH = 3'd5,
        REG_PAL_HIGH = 3'd6
    } reg_idx_t;

    // dot patterns, even columns in the first half, odd columns in the second
    localparam logic [DOT_W-1:0] DOT_TABLE [32] = '{
        7'h00, 7'h11, 7'h22, 7'h33, 7'h44, 7'h55, 7'h66, 7'h77,
        7'h08, 7'h19, 7'h2A, 7'h3B, 7'h4C, 7'h5D, 7'h6E, 7'h7F,
        7'h00, 7'h44, 7'h08, 7'h4C, 7'h11, 7'h55, 7'h19, 7'h5D,
        7'h22, 7'h66, 7'h2A, 7'h6E, 7'h33, 7'h77, 7'h3B, 7'h7F
    };

    typedef struct packed {
        logic                       mono_mode;
        logic [PIX_W-1:0]           fore_color;
        logic [PIX_W-1:0]           back_color;
        logic [3:0][REG_W-1:0]      palette;
    } cfg_t;

    typedef struct packed {
        logic             line_end;
        logic [DOT_W-1:0] aux_upper;
        logic [DOT_W-1:0] aux_lower;
        logic [DOT_W-1:0] main_upper;
        logic [DOT_W-1:0] main_lower;
    } col_entry_t;

endpackage

// ===== rtl/dlsr_cfg.sv =====
module dlsr_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlsr_pkg::ADDR_W-1:0]   paddr,
    input  logic [dlsr_pkg::REG_W-1:0]    pwdata,
    output logic [dlsr_pkg::REG_W-1:0]    prdata,
    output dlsr_pkg::cfg_t                cfg
);
    import dlsr_pkg::*;

    logic                  mono_reg;
    logic [PIX_W-1:0]      fore_reg;
    logic [PIX_W-1:0]      back_reg;
    logic [3:0][REG_W-1:0] pal_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg <= 1'b0;
            fore_reg <= {PIX_W{1'b1}};
            back_reg <= '0;
            pal_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MONO:      mono_reg   <= pwdata[0];
                REG_FORE:      fore_reg   <= pwdata[PIX_W-1:0];
                REG_BACK:      back_reg   <= pwdata[PIX_W-1:0];
                REG_PAL_LOW:   pal_reg[0] <= pwdata;
                REG_PAL_MLOW:  pal_reg[1] <= pwdata;
                REG_PAL_MHIGH: pal_reg[2] <= pwdata;
                REG_PAL_HIGH:  pal_reg[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MONO:      prdata = REG_W'(mono_reg);
            REG_FORE:      prdata = REG_W'(fore_reg);
            REG_BACK:      prdata = REG_W'(back_reg);
            REG_PAL_LOW:   prdata = pal_reg[0];
            REG_PAL_MLOW:  prdata = pal_reg[1];
            REG_PAL_MHIGH: prdata = pal_reg[2];
            REG_PAL_HIGH:  prdata = pal_reg[3];
            default:       prdata = '0;
        endcase
    end

    assign cfg.mono_mode  = mono_reg;
    assign cfg.fore_color = fore_reg;
    assign cfg.back_color = back_reg;
    assign cfg.palette    = pal_reg;

endmodule

// ===== rtl/dlsr_front.sv =====
module dlsr_front
#(
    parameter int COLUMNS = dlsr_pkg::COLUMNS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    output logic                 push,
    output dlsr_pkg::col_entry_t push_entry,
    input  logic                 q_full
);
    import dlsr_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             last_col;
    logic [7:0]       main_byte;
    logic [7:0]       aux_byte;

    assign main_byte = s_tdata[7:0];
    assign aux_byte  = s_tdata[15:8];
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;
    assign last_col  = (col_reg == COL_W'(COLUMNS - 1));

    assign push_entry.line_end   = last_col;
    assign push_entry.aux_upper  = DOT_TABLE[{col_reg[0], aux_byte[3:0]}];
    assign push_entry.aux_lower  = DOT_TABLE[{col_reg[0], aux_byte[7:4]}];
    assign push_entry.main_upper = DOT_TABLE[{col_reg[0], main_byte[3:0]}];
    assign push_entry.main_lower = DOT_TABLE[{col_reg[0], main_byte[7:4]}];

    always_comb
    begin
        col_next = col_reg;
        if (push)
        begin
            col_next = last_col ? '0 : col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

endmodule

// ===== rtl/dlsr_queue.sv =====
module dlsr_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dlsr_pkg::col_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output dlsr_pkg::col_entry_t q_entry
);
    import dlsr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    col_entry_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dlsr_back.sv =====
module dlsr_back
#(
    parameter int PIXEL_BITS = dlsr_pkg::PIXEL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlsr_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  dlsr_pkg::col_entry_t q_entry,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);
    import dlsr_pkg::*;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WORD = 3'b010,
        ST_PAIR = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [ACC_W-1:0]  up_reg, up_next;
    logic [ACC_W-1:0]  lo_reg, lo_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic              last_reg, last_next;

    logic              ovalid_reg, ovalid_next;
    logic [63:0]       odata_reg, odata_next;
    logic              olast_reg, olast_next;
    logic              ouser_reg, ouser_next;

    logic              out_free;
    logic [HELD_W-1:0] held_sub4;
    logic [HELD_W-1:0] held_hi;
    logic              color_done;
    logic [3:0]        u0, u1, u2, u3, l0, l1, l2, l3;
    logic [63:0]       mono_word, pair0_word, pair1_word;

    function automatic logic [PIX_W-1:0] pal_pick(input cfg_t c, input logic [3:0] e);
        logic [REG_W-1:0] r;
        r = c.palette[e[3:2]];
        return r[e[1:0]*PIX_W +: PIX_W] & PIX_MASK;
    endfunction

    function automatic logic [PIX_W-1:0] mono_pick(input cfg_t c, input logic dot);
        return (dot ? c.fore_color : c.back_color) & PIX_MASK;
    endfunction

    assign out_free  = !ovalid_reg || m_tready;
    assign held_hi   = held_reg + HELD_W'(DOT_W);
    assign held_sub4 = (held_reg >= HELD_W'(4)) ? held_reg - HELD_W'(4) : '0;
    assign color_done = (held_sub4 < HELD_W'(8)) && !(last_reg && held_sub4 != '0);

    // sliding palette window over the eight oldest dots
    assign u0 = {up_reg[3:1], up_reg[4]};
    assign u1 = {up_reg[3:2], up_reg[5:4]};
    assign u2 = {up_reg[3],   up_reg[6:4]};
    assign u3 = up_reg[7:4];
    assign l0 = {lo_reg[3:1], lo_reg[4]};
    assign l1 = {lo_reg[3:2], lo_reg[5:4]};
    assign l2 = {lo_reg[3],   lo_reg[6:4]};
    assign l3 = lo_reg[7:4];

    assign mono_word  = {mono_pick(cfg, lo_reg[1]), mono_pick(cfg, lo_reg[0]),
                         mono_pick(cfg, up_reg[1]), mono_pick(cfg, up_reg[0])};
    assign pair0_word = {pal_pick(cfg, l1), pal_pick(cfg, l0),
                         pal_pick(cfg, u1), pal_pick(cfg, u0)};
    assign pair1_word = {pal_pick(cfg, l3), pal_pick(cfg, l2),
                         pal_pick(cfg, u3), pal_pick(cfg, u2)};

    always_comb
    begin
        state_next  = state_reg;
        up_next     = up_reg;
        lo_next     = lo_reg;
        held_next   = held_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ouser_next  = ouser_reg;
        pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pop = 1'b1;
                if (q_valid)
                begin
                    up_next = up_reg
                            | (ACC_W'(q_entry.aux_upper) << held_reg)
                            | (ACC_W'(q_entry.main_upper) << held_hi);
                    lo_next = lo_reg
                            | (ACC_W'(q_entry.aux_lower) << held_reg)
                            | (ACC_W'(q_entry.main_lower) << held_hi);
                    held_next  = held_reg + HELD_W'(2 * DOT_W);
                    last_next  = q_entry.line_end;
                    state_next = ST_WORD;
                end
            end
            ST_WORD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b0;
                    ouser_next  = 1'b0;
                    if (cfg.mono_mode)
                    begin
                        odata_next = mono_word;
                        up_next    = up_reg >> 2;
                        lo_next    = lo_reg >> 2;
                        held_next  = held_reg - HELD_W'(2);
                        if (held_reg < HELD_W'(4))
                        begin
                            ouser_next = 1'b1;
                            olast_next = last_reg;
                            state_next = ST_IDLE;
                            if (last_reg)
                            begin
                                up_next   = '0;
                                lo_next   = '0;
                                held_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        odata_next = pair0_word;
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_PAIR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = pair1_word;
                    olast_next  = 1'b0;
                    ouser_next  = 1'b0;
                    up_next     = up_reg >> 4;
                    lo_next     = lo_reg >> 4;
                    held_next   = held_sub4;
                    state_next  = ST_WORD;
                    if (color_done)
                    begin
                        ouser_next = 1'b1;
                        olast_next = last_reg;
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            up_next   = '0;
                            lo_next   = '0;
                            held_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            up_reg     <= '0;
            lo_reg     <= '0;
            held_reg   <= '0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            up_reg     <= up_next;
            lo_reg     <= lo_next;
            held_reg   <= held_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        ouser_reg <= ouser_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

endmodule

// ===== rtl/double_lores_scanline_render_top.sv =====
// Double low-res scanline renderer.
// Input stream: one request per text column, s_tdata = {aux_byte, main_byte}.
// Output stream: one request per scanline word, m_tdata holds four pixels
// for the upper and lower cells; m_tuser marks the last word of a column,
// m_tlast the last word of the row (after COLUMNS columns).
// Configuration: APB, 64-bit registers at byte address 8*index; write only
// while the stream is idle.
// Flow: a column passes the queue, is loaded into the dot accumulators and
// then leaves as words through the output register, one word per cycle
// while the output register is free. A column gives 7 words in mono mode,
// 4, 6 or 8 in color mode, up to 10 on the first mono column after color
// dots are left over and up to 10 on the last column of a row.
// A two-entry queue in front of the renderer accepts columns while it works.
// When m_tready is low the output register holds its word, the renderer
// waits, and s_tready falls once the queue is full. Reset clears the
// accumulators, the column counter, the queue and the registers (fore
// color resets to all ones).
module double_lores_scanline_render_top
#(
    parameter int COLUMNS    = dlsr_pkg::COLUMNS_DEF,
    parameter int PIXEL_BITS = dlsr_pkg::PIXEL_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // main_byte, aux_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // upper_left_pixel, upper_right_pixel,
                                                   // lower_left_pixel, lower_right_pixel
    output logic                        m_tlast,   // end_of_line
    output logic                        m_tuser,   // last_of_item
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dlsr_pkg::ADDR_W-1:0] paddr,
    input  logic [dlsr_pkg::REG_W-1:0]  pwdata,
    output logic [dlsr_pkg::REG_W-1:0]  prdata,
    output logic                        pready
);
    import dlsr_pkg::*;

    cfg_t       cfg;
    logic       push;
    col_entry_t push_entry;
    logic       q_full;
    logic       pop;
    logic       q_valid;
    col_entry_t q_entry;

    assign pready = 1'b1;

    dlsr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dlsr_front #(.COLUMNS(COLUMNS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    dlsr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    dlsr_back #(.PIXEL_BITS(PIXEL_BITS)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import dlsr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int COLS          = COLUMNS_DEF;
    localparam int PIX_BITS      = PIXEL_BITS_DEF;
    localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIX_BITS) - 32'd1);
    localparam int ITEMS         = 320;
    localparam int MAX_WORDS     = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int REG_UNUSED    = NUM_REGS;

    // dot patterns, even columns first, odd columns second
    localparam logic [6:0] DOTS [32] = '{
        7'h00, 7'h11, 7'h22, 7'h33, 7'h44, 7'h55, 7'h66, 7'h77,
        7'h08, 7'h19, 7'h2A, 7'h3B, 7'h4C, 7'h5D, 7'h6E, 7'h7F,
        7'h00, 7'h44, 7'h08, 7'h4C, 7'h11, 7'h55, 7'h19, 7'h5D,
        7'h22, 7'h66, 7'h2A, 7'h6E, 7'h33, 7'h77, 7'h3B, 7'h7F
    };

    typedef struct packed {
        logic [15:0] upper_left;
        logic [15:0] upper_right;
        logic [15:0] lower_left;
        logic [15:0] lower_right;
        logic        last_of_column;
        logic        end_of_row;
    } pixel_word_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // main_byte, aux_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;         // upper_left, upper_right, lower_left, lower_right
    logic              m_tlast;         // end_of_line
    logic              m_tuser;         // last_of_item
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [REG_W-1:0]  pwdata   = '0;
    logic [REG_W-1:0]  prdata;
    logic              pready;

    // shadow registers
    logic        cfg_mono = 1'b0;
    logic [15:0] cfg_fore = 16'hFFFF;
    logic [15:0] cfg_back = 16'h0000;
    logic [63:0] cfg_pal [4] = '{64'd0, 64'd0, 64'd0, 64'd0};

    // renderer state
    logic [31:0] acc_upper = '0;
    logic [31:0] acc_lower = '0;
    int          held      = 0;
    int          col_pos   = 0;

    pixel_word_t expected_words [$];
    logic [15:0] col_queue [$];
    int          columns_queued = 0;
    int          columns_taken  = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;

    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          hold_asks  = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    logic [3:0]  rx_step    = '0;
    int          burst_left = 0;
    int          gap_left   = 0;

    double_lores_scanline_render_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [15:0] mono_pixel(input logic dot);
        return (dot ? cfg_fore : cfg_back) & PIX_MASK;
    endfunction

    function automatic logic [15:0] palette_pixel(input logic [3:0] entry);
        return cfg_pal[entry[3:2]][int'(entry[1:0]) * 16 +: 16] & PIX_MASK;
    endfunction

    function automatic void render_column(input logic [7:0] main_b, input logic [7:0] aux_b);
        logic        row_end;
        logic [7:0]  uw;
        logic [7:0]  lw;
        pixel_word_t word;
        pixel_word_t col_words [$];
        row_end = (col_pos >= COLS - 1);
        acc_upper |= 32'(DOTS[{col_pos[0], aux_b[3:0]}]) << held;
        acc_lower |= 32'(DOTS[{col_pos[0], aux_b[7:4]}]) << held;
        held += 7;
        acc_upper |= 32'(DOTS[{col_pos[0], main_b[3:0]}]) << held;
        acc_lower |= 32'(DOTS[{col_pos[0], main_b[7:4]}]) << held;
        held += 7;
        if (cfg_mono)
        begin
            while (held >= 2 && col_words.size() < MAX_WORDS)
            begin
                word = '0;
                word.upper_left  = mono_pixel(acc_upper[0]);
                word.upper_right = mono_pixel(acc_upper[1]);
                word.lower_left  = mono_pixel(acc_lower[0]);
                word.lower_right = mono_pixel(acc_lower[1]);
                col_words.push_back(word);
                acc_upper >>= 2;
                acc_lower >>= 2;
                held -= 2;
            end
        end
        else
        begin
            // sliding window, flush on the last column of the row
            while ((held >= 8 || (row_end && held > 0)) && col_words.size() < MAX_WORDS)
            begin
                uw = acc_upper[7:0];
                lw = acc_lower[7:0];
                word = '0;
                word.upper_left  = palette_pixel({uw[3:1], uw[4]});
                word.upper_right = palette_pixel({uw[3:2], uw[5:4]});
                word.lower_left  = palette_pixel({lw[3:1], lw[4]});
                word.lower_right = palette_pixel({lw[3:2], lw[5:4]});
                col_words.push_back(word);
                word.upper_left  = palette_pixel({uw[3], uw[6:4]});
                word.upper_right = palette_pixel(uw[7:4]);
                word.lower_left  = palette_pixel({lw[3], lw[6:4]});
                word.lower_right = palette_pixel(lw[7:4]);
                col_words.push_back(word);
                acc_upper >>= 4;
                acc_lower >>= 4;
                held = (held >= 4) ? held - 4 : 0;
            end
        end
        if (col_words.size() > 0)
        begin
            word = col_words.pop_back();
            word.last_of_column = 1'b1;
            word.end_of_row     = row_end;
            col_words.push_back(word);
        end
        foreach (col_words[i])
            expected_words.push_back(col_words[i]);
        if (row_end)
        begin
            acc_upper = '0;
            acc_lower = '0;
            held      = 0;
            col_pos   = 0;
        end
        else
        begin
            col_pos = (col_pos + 1) & 63;
        end
    endfunction

    function automatic void log_mismatch(input string what, input pixel_word_t seen,
                                         input pixel_word_t want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%s: got ul=%h ur=%h ll=%h lr=%h col=%b row=%b, ",
                      "want ul=%h ur=%h ll=%h lr=%h col=%b row=%b"},
                     what, seen.upper_left, seen.upper_right, seen.lower_left,
                     seen.lower_right, seen.last_of_column, seen.end_of_row,
                     want.upper_left, want.upper_right, want.lower_left,
                     want.lower_right, want.last_of_column, want.end_of_row);
    endfunction

    // driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic        next_valid;
        logic [15:0] next_data;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (!s_tvalid || s_tready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0 && !tx_calm)
                begin
                    gap_left--;
                end
                else if (col_queue.size() > 0)
                begin
                    next_data  = col_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0 && !tx_calm)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                                 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // receiver: stall pattern plus an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rx_calm | rx_pattern[rx_step];
            end
            rx_step++;
        end
    end

    // monitor, prediction and watchdog
    always @(posedge clk)
    begin
        pixel_word_t seen;
        pixel_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                        m_tuser, m_tlast};
                if (expected_words.size() == 0)
                begin
                    want = '0;
                    log_mismatch("word with none pending", seen, want);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (seen !== want)
                        log_mismatch("word differs", seen, want);
                end
            end
            if (s_tvalid && s_tready)
            begin
                render_column(s_tdata[7:0], s_tdata[15:8]);
                columns_taken++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input int idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MONO:      cfg_mono = value[0];
            REG_FORE:      cfg_fore = value[15:0];
            REG_BACK:      cfg_back = value[15:0];
            REG_PAL_LOW:   cfg_pal[0] = value;
            REG_PAL_MLOW:  cfg_pal[1] = value;
            REG_PAL_MHIGH: cfg_pal[2] = value;
            REG_PAL_HIGH:  cfg_pal[3] = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic queue_column(input logic [15:0] column);
        col_queue.push_back(column);
        columns_queued++;
    endtask

    task automatic drain_pipeline();
        while (columns_taken != columns_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_column();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_palette();
        case ($urandom_range(0, 3))
            0: return 64'd0;
            1: return '1;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic run_columns(input int count);
        repeat (count) queue_column(random_column());
        drain_pipeline();
    endtask

    initial
    begin
        int k;
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mono with full-scale colors, nibble sweep
        write_reg(REG_MONO, 64'd1);
        write_reg(REG_FORE, 64'hFFFF);
        write_reg(REG_BACK, 64'h0000);
        queue_column(16'h0000);
        queue_column(16'hFFFF);
        for (k = 0; k < 6; k++)
            queue_column({4'(4 * k + 3), 4'(4 * k + 2), 4'(4 * k + 1), 4'(4 * k)});
        drain_pipeline();

        // color mode in the middle of the row
        write_reg(REG_MONO, 64'd0);
        write_reg(REG_PAL_LOW,   {32'($urandom), 32'($urandom)});
        write_reg(REG_PAL_MLOW,  {32'($urandom), 32'($urandom)});
        write_reg(REG_PAL_MHIGH, {32'($urandom), 32'($urandom)});
        write_reg(REG_PAL_HIGH,  {32'($urandom), 32'($urandom)});
        queue_column(16'hFFFF);
        queue_column(16'h0000);
        queue_column(16'h0FF0);
        queue_column(16'hF00F);
        for (k = 6; k < 10; k++)
            queue_column({4'(4 * k + 3), 4'(4 * k + 2), 4'(4 * k + 1), 4'(4 * k)});
        drain_pipeline();

        // back to mono, leftover color dots drawn as plain dots
        write_reg(REG_MONO, 64'd1);
        write_reg(REG_FORE, 64'h0000);
        write_reg(REG_BACK, 64'hFFFF);
        queue_column(16'h5AA5);
        queue_column(16'hA55A);
        repeat (3) queue_column(random_column());
        drain_pipeline();

        phase = 0;
        while (columns_queued < ITEMS)
        begin
            // first phase runs color mode through the end of a row
            write_reg(REG_MONO, (phase == 0) ? 64'd0 : 64'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                write_reg(REG_FORE, 64'(pick_color()));
                write_reg(REG_BACK, 64'(pick_color()));
                write_reg(REG_PAL_LOW,   pick_palette());
                write_reg(REG_PAL_MLOW,  pick_palette());
                write_reg(REG_PAL_MHIGH, pick_palette());
                write_reg(REG_PAL_HIGH,  pick_palette());
            end
            if (phase == 1)
                write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
            tx_calm    = ($urandom_range(0, 3) == 0);
            rx_calm    = ($urandom_range(0, 3) == 0);
            rx_pattern = 16'($urandom) | 16'h0001;
            if (phase == 2)
            begin
                tx_calm = 1'b1;
                hold_asks++;
            end
            run_columns((phase == 0) ? COLS - col_pos + $urandom_range(0, 8)
                                     : $urandom_range(4, 40));
            phase++;
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
